@@ hdl/bcq_pkg.sv @@
// ============================================================================
// bcq_pkg: shared types and constants for the box corner quadratic check
// Fixed-point widths, the quadratic form coefficients and the term layout
// used by the corner evaluation pipeline and the top level.
// ============================================================================
package bcq_pkg;

    // Input and output formats
    localparam int DATA_WIDTH  = 24;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_FRAC    = 24;
    localparam int OUT_WIDTH   = 48;
    localparam int LEVEL_WIDTH = OUT_WIDTH - 1;

    // Box geometry
    localparam int DIM_COUNT   = 4;
    localparam int CORNER_BITS = DIM_COUNT;
    localparam int NUM_CORNERS = 1 << CORNER_BITS;
    localparam int NUM_TERMS   = DIM_COUNT * (DIM_COUNT + 1) / 2;

    // Datapath widths
    localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
    localparam int LO_WIDTH    = DATA_WIDTH;
    localparam int HI_WIDTH    = PROD_WIDTH - LO_WIDTH;
    // largest coefficient is below 34, doubled cross terms below 16
    localparam int COEF_WIDTH  = FRAC_BITS + 7;
    localparam int HIC_WIDTH   = HI_WIDTH + COEF_WIDTH + 1;
    localparam int LOC_WIDTH   = LO_WIDTH + COEF_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + COEF_WIDTH + 5;
    localparam int OUT_SHIFT   = 3 * FRAC_BITS - OUT_FRAC;

    localparam longint unsigned COEF_SCALE = 64'd10000;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic        [COEF_WIDTH-1:0] coef_t;
    typedef logic signed [HIC_WIDTH-1:0]  hic_t;
    typedef logic        [LOC_WIDTH-1:0]  loc_t;
    typedef logic signed [ACC_WIDTH-1:0]  acc_t;
    typedef logic signed [OUT_WIDTH-1:0]  value_t;
    typedef logic        [LEVEL_WIDTH-1:0] level_t;
    typedef logic        [CORNER_BITS-1:0] corner_t;

    // Control that travels with each corner through the pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } ctl_t;

    localparam level_t  LEVEL_RESET = level_t'(64'd1 << OUT_FRAC);
    localparam corner_t CORNER_LAST = corner_t'(NUM_CORNERS - 1);

    // Symmetric matrix, decimal coefficients times COEF_SCALE
    localparam longint unsigned MAT_DEC [DIM_COUNT][DIM_COUNT] = '{
        '{64'd10520,  64'd12082,  64'd2580,  64'd1988},
        '{64'd12082,  64'd339334, 64'd46631, 64'd40269},
        '{64'd2580,   64'd46631,  64'd22108, 64'd10090},
        '{64'd1988,   64'd40269,  64'd10090, 64'd8424}
    };

    // Vector element i takes box dimension X_DIM[i]
    localparam int X_DIM [DIM_COUNT] = '{0, 2, 1, 3};

    // Upper triangle of the form: diagonal terms, then cross terms
    localparam int TERM_ROW [NUM_TERMS] = '{0, 1, 2, 3, 0, 0, 0, 1, 1, 2};
    localparam int TERM_COL [NUM_TERMS] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};

    // Q-format coefficient of one term, rounded half up; cross terms doubled
    function automatic coef_t term_coef(input int k);
        longint unsigned dec;
        longint unsigned q;
        dec = MAT_DEC[TERM_ROW[k]][TERM_COL[k]];
        q   = (dec * (64'd1 << FRAC_BITS) + COEF_SCALE / 2) / COEF_SCALE;
        if (TERM_ROW[k] != TERM_COL[k])
        begin
            q = q << 1;
        end
        return coef_t'(q);
    endfunction

endpackage

@@ hdl/box_corner_quadratic_max_check.sv @@
// ============================================================================
// box_corner_quadratic_max_check: largest quadratic form over 4-D box corners
// Walks the 16 corners of a box through a pipelined x^T P x unit, keeps the
// running maximum and flags the box safe when it lies below safe_level.
// ============================================================================
//
//  channel   signals                          direction  handshake
//  --------  -------------------------------  ---------  ---------------------
//  request   start, busy, dim*_low/high       in         start && !busy
//  result    done, max_value, is_safe         out        done, one cycle
//  config    cfg_valid, cfg_ready, cfg_data   in         cfg_valid && cfg_ready
//
//  One corner enters the quadratic form pipeline per cycle, and a new request
//  is taken on the last corner of the previous box, so boxes overlap.
//  A request reaches done through the corner walk, the corner register, the
//  six-stage form pipeline, the max register and the output register.
//  Reset clears the corner walk, all valid bits and sets safe_level to 1.0.
//  The receiver cannot stall; results are never held back.
//
module box_corner_quadratic_max_check
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  bcq_pkg::data_t           dim0_low,
    input  bcq_pkg::data_t           dim0_high,
    input  bcq_pkg::data_t           dim1_low,
    input  bcq_pkg::data_t           dim1_high,
    input  bcq_pkg::data_t           dim2_low,
    input  bcq_pkg::data_t           dim2_high,
    input  bcq_pkg::data_t           dim3_low,
    input  bcq_pkg::data_t           dim3_high,
    output logic                     done,
    output bcq_pkg::value_t          max_value,
    output logic                     is_safe,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  bcq_pkg::level_t          cfg_data
);

    logic              accept;
    logic              active_reg;
    logic              active_next;
    bcq_pkg::corner_t  cnt_reg;
    bcq_pkg::corner_t  cnt_next;
    bcq_pkg::level_t   level_reg;

    bcq_pkg::data_t    lo_reg    [bcq_pkg::DIM_COUNT];
    bcq_pkg::data_t    hi_reg    [bcq_pkg::DIM_COUNT];
    bcq_pkg::data_t    lo_in     [bcq_pkg::DIM_COUNT];
    bcq_pkg::data_t    hi_in     [bcq_pkg::DIM_COUNT];
    bcq_pkg::data_t    dim_val   [bcq_pkg::DIM_COUNT];
    bcq_pkg::data_t    corner_reg[bcq_pkg::DIM_COUNT];
    bcq_pkg::data_t    corner_next[bcq_pkg::DIM_COUNT];
    bcq_pkg::ctl_t     corner_ctl_reg;
    bcq_pkg::ctl_t     corner_ctl_next;

    bcq_pkg::ctl_t     eval_ctl;
    bcq_pkg::value_t   eval_value;

    logic              fin_reg;
    bcq_pkg::value_t   best_reg;
    bcq_pkg::value_t   best_next;
    logic              done_reg;
    bcq_pkg::value_t   max_value_reg;
    logic              is_safe_reg;

    // Request handshake: busy drops on the last corner so boxes overlap
    assign busy   = active_reg && (cnt_reg != bcq_pkg::CORNER_LAST);
    assign accept = start && !busy;

    // Corner walk
    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (accept)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
        end
        else if (active_reg)
        begin
            if (cnt_reg == bcq_pkg::CORNER_LAST)
            begin
                active_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + bcq_pkg::corner_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= bcq_pkg::LEVEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            level_reg <= cfg_data;
        end
    end

    // Box bounds captured on request
    assign lo_in[0] = dim0_low;
    assign lo_in[1] = dim1_low;
    assign lo_in[2] = dim2_low;
    assign lo_in[3] = dim3_low;
    assign hi_in[0] = dim0_high;
    assign hi_in[1] = dim1_high;
    assign hi_in[2] = dim2_high;
    assign hi_in[3] = dim3_high;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg <= lo_in;
            hi_reg <= hi_in;
        end
    end

    // Corner select: dimension 0 follows the top counter bit
    for (genvar d = 0; d < bcq_pkg::DIM_COUNT; d++)
    begin : g_dim
        assign dim_val[d] = cnt_reg[bcq_pkg::CORNER_BITS-1-d] ? hi_reg[d] : lo_reg[d];
    end

    for (genvar i = 0; i < bcq_pkg::DIM_COUNT; i++)
    begin : g_vec
        assign corner_next[i] = dim_val[bcq_pkg::X_DIM[i]];
    end

    always_comb
    begin
        corner_ctl_next.valid = active_reg;
        corner_ctl_next.first = (cnt_reg == '0);
        corner_ctl_next.last  = (cnt_reg == bcq_pkg::CORNER_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_ctl_reg <= '0;
        end
        else
        begin
            corner_ctl_reg <= corner_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        corner_reg <= corner_next;
    end

    // Quadratic form pipeline
    bcq_corner_eval u_eval
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (corner_ctl_reg),
        .in_x      (corner_reg),
        .out_ctl   (eval_ctl),
        .out_value (eval_value)
    );

    // Running maximum over the corners of one box
    always_comb
    begin
        best_next = best_reg;
        if (eval_ctl.valid)
        begin
            if (eval_ctl.first || (eval_value > best_reg))
            begin
                best_next = eval_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fin_reg  <= eval_ctl.valid && eval_ctl.last;
            done_reg <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        if (fin_reg)
        begin
            max_value_reg <= best_reg;
            is_safe_reg   <= (best_reg < $signed({1'b0, level_reg}));
        end
    end

    assign done      = done_reg;
    assign max_value = max_value_reg;
    assign is_safe   = is_safe_reg;

endmodule

@@ hdl/bcq_corner_eval.sv @@
// ============================================================================
// bcq_corner_eval: pipelined quadratic form x^T P x for one corner per cycle
// Six register stages: products, coefficient partial products, pair sums,
// partial sums, total, scale and saturate. Control travels with the data.
// ============================================================================
module bcq_corner_eval
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bcq_pkg::ctl_t         in_ctl,
    input  bcq_pkg::data_t        in_x [bcq_pkg::DIM_COUNT],
    output bcq_pkg::ctl_t         out_ctl,
    output bcq_pkg::value_t       out_value
);

    localparam int NUM_STAGES = 6;
    localparam int NUM_PAIRS  = bcq_pkg::NUM_TERMS / 2;

    localparam bcq_pkg::acc_t SAT_MAX =
        bcq_pkg::acc_t'((64'sd1 <<< (bcq_pkg::OUT_WIDTH - 1)) - 64'sd1);
    localparam bcq_pkg::acc_t SAT_MIN = -SAT_MAX - bcq_pkg::acc_t'(1);

    bcq_pkg::ctl_t  ctl_reg  [NUM_STAGES];

    bcq_pkg::prod_t prod_reg [bcq_pkg::NUM_TERMS];
    bcq_pkg::prod_t prod_next[bcq_pkg::NUM_TERMS];
    bcq_pkg::hic_t  hic_reg  [bcq_pkg::NUM_TERMS];
    bcq_pkg::hic_t  hic_next [bcq_pkg::NUM_TERMS];
    bcq_pkg::loc_t  loc_reg  [bcq_pkg::NUM_TERMS];
    bcq_pkg::loc_t  loc_next [bcq_pkg::NUM_TERMS];
    bcq_pkg::acc_t  term     [bcq_pkg::NUM_TERMS];
    bcq_pkg::acc_t  pair_reg [NUM_PAIRS];
    bcq_pkg::acc_t  pair_next[NUM_PAIRS];
    bcq_pkg::acc_t  part_a_reg;
    bcq_pkg::acc_t  part_a_next;
    bcq_pkg::acc_t  part_b_reg;
    bcq_pkg::acc_t  part_b_next;
    bcq_pkg::acc_t  total_reg;
    bcq_pkg::acc_t  total_next;
    bcq_pkg::acc_t  scaled;
    bcq_pkg::value_t value_reg;
    bcq_pkg::value_t value_next;

    // Control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= in_ctl;
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    // Per-term products and coefficient partial products
    for (genvar k = 0; k < bcq_pkg::NUM_TERMS; k++)
    begin : g_term
        localparam bcq_pkg::coef_t COEF = bcq_pkg::term_coef(k);

        // x_i * x_j, exact in PROD_WIDTH bits
        assign prod_next[k] = bcq_pkg::prod_t'(in_x[bcq_pkg::TERM_ROW[k]])
                            * bcq_pkg::prod_t'(in_x[bcq_pkg::TERM_COL[k]]);

        // product split into signed high and unsigned low halves
        assign hic_next[k] =
            bcq_pkg::hic_t'($signed(prod_reg[k][bcq_pkg::PROD_WIDTH-1:bcq_pkg::LO_WIDTH]))
            * bcq_pkg::hic_t'($signed({1'b0, COEF}));
        assign loc_next[k] = bcq_pkg::loc_t'(prod_reg[k][bcq_pkg::LO_WIDTH-1:0])
                           * bcq_pkg::loc_t'(COEF);

        // recombine halves
        assign term[k] = (bcq_pkg::acc_t'(hic_reg[k]) <<< bcq_pkg::LO_WIDTH)
                       + bcq_pkg::acc_t'(loc_reg[k]);
    end

    // Pair sums
    for (genvar p = 0; p < NUM_PAIRS; p++)
    begin : g_pair
        assign pair_next[p] = term[2*p] + term[2*p+1];
    end

    // Partial sums, total, scale and saturate
    always_comb
    begin
        part_a_next = pair_reg[0] + pair_reg[1];
        part_b_next = pair_reg[2] + pair_reg[3] + pair_reg[4];
        total_next  = part_a_reg + part_b_reg;
        scaled      = total_reg >>> bcq_pkg::OUT_SHIFT;
        priority if (scaled > SAT_MAX)
        begin
            value_next = bcq_pkg::value_t'(SAT_MAX);
        end
        else if (scaled < SAT_MIN)
        begin
            value_next = bcq_pkg::value_t'(SAT_MIN);
        end
        else
        begin
            value_next = bcq_pkg::value_t'(scaled);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        hic_reg    <= hic_next;
        loc_reg    <= loc_next;
        pair_reg   <= pair_next;
        part_a_reg <= part_a_next;
        part_b_reg <= part_b_next;
        total_reg  <= total_next;
        value_reg  <= value_next;
    end

    assign out_ctl   = ctl_reg[NUM_STAGES-1];
    assign out_value = value_reg;

endmodule

@@ hdl/bcq_checker.sv @@
// ============================================================================
// bcq_checker: port-level checks for box_corner_quadratic_max_check
// Watches request, result and busy behavior over time; bound to the top.
// ============================================================================
module bcq_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input bcq_pkg::value_t      max_value,
    input logic                 is_safe
);

    // A taken request starts a corner walk
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");

    // busy only rises because of a request
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without request");

    // Results are at least one box period apart
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done ##1 !done ##1 !done ##1 !done ##1 !done ##1 !done
                 ##1 !done ##1 !done ##1 !done ##1 !done ##1 !done ##1 !done
                 ##1 !done ##1 !done ##1 !done)
        else $error("results closer than one box period");

    // The level is never negative, so a negative maximum is always safe
    a_neg_safe: assert property (@(posedge clk) disable iff (!rst_n)
        done && max_value[bcq_pkg::OUT_WIDTH-1] |-> is_safe)
        else $error("negative maximum flagged unsafe");

endmodule

bind box_corner_quadratic_max_check bcq_checker u_bcq_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Box corner quadratic maximum check: testbench
// Sends 4-D boxes through the start/busy port and checks every done strobe
// against an in-bench model of the largest x^T P x over the 16 box corners.
// A short table of directed boxes runs first, then phases of random boxes,
// each under its own safe_level setting written while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [95:0] wide_t;

    typedef struct packed {
        bcq_pkg::data_t d0_lo, d0_hi, d1_lo, d1_hi, d2_lo, d2_hi, d3_lo, d3_hi;
    } box_t;

    typedef struct packed {
        bcq_pkg::value_t max_value;
        logic            is_safe;
    } outcome_t;

    typedef struct packed {
        box_t     box;
        logic     typed;
        outcome_t outcome;
    } directed_row_t;

    localparam bcq_pkg::data_t D_MAX = 24'sh7FFFFF;
    localparam bcq_pkg::data_t D_MIN = 24'sh800000;
    localparam bcq_pkg::data_t D_ONE = 24'sd65536;
    localparam bcq_pkg::data_t D_HALF = 24'sd32768;
    localparam bcq_pkg::data_t D_NEG1 = 24'shFFFFFF;
    localparam bcq_pkg::data_t D_LSB = 24'sd1;
    localparam bcq_pkg::data_t D_A = 24'shAAAAAA;
    localparam bcq_pkg::data_t D_5 = 24'sh555555;

    localparam bcq_pkg::level_t LEVEL_ONE = bcq_pkg::level_t'(47'd1 << 24);
    localparam bcq_pkg::level_t LEVEL_TOP = '1;
    localparam int NUM_PHASES = 10;
    localparam int BOXES_PER_PHASE = 54;
    localparam int DRAIN_CYCLES = 30;
    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_DIRECTED = 13;

    // P times 10^4, symmetric, in vector order (dim0, dim2, dim1, dim3)
    localparam longint MATRIX_E4 [4][4] = '{
        '{10520, 12082, 2580, 1988},
        '{12082, 339334, 46631, 40269},
        '{2580, 46631, 22108, 10090},
        '{1988, 40269, 10090, 8424}
    };

    // Directed boxes; only the all-zero box has its result typed in
    localparam directed_row_t DIRECTED_BOXES [NUM_DIRECTED] = '{
        '{'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
          1'b1, '{48'sd0, 1'b1}},
        '{'{D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX},
          1'b0, '0},
        '{'{D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN},
          1'b0, '0},
        '{'{D_MIN, D_MAX, D_MIN, D_MAX, D_MIN, D_MAX, D_MIN, D_MAX},
          1'b0, '0},
        '{'{D_MAX, D_MIN, D_MAX, D_MIN, D_MAX, D_MIN, D_MAX, D_MIN},
          1'b0, '0},
        '{'{D_ONE, D_ONE, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
          1'b0, '0},
        '{'{24'sd0, 24'sd0, -D_ONE, -D_ONE, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
          1'b0, '0},
        '{'{24'sd0, 24'sd0, 24'sd0, 24'sd0, D_HALF, D_ONE + D_HALF, 24'sd0, 24'sd0},
          1'b0, '0},
        '{'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
            bcq_pkg::data_t'(-2 * D_ONE), bcq_pkg::data_t'(3 * D_ONE)},
          1'b0, '0},
        '{'{D_NEG1, D_NEG1, D_NEG1, D_NEG1, D_NEG1, D_NEG1, D_NEG1, D_NEG1},
          1'b0, '0},
        '{'{D_A, D_5, D_5, D_A, D_A, D_5, D_5, D_A},
          1'b0, '0},
        '{'{D_ONE, -D_ONE, D_ONE, -D_ONE, D_ONE, -D_ONE, D_ONE, -D_ONE},
          1'b0, '0},
        '{'{D_LSB, D_LSB, -D_LSB, D_LSB, D_LSB, -D_LSB, -D_LSB, -D_LSB},
          1'b0, '0}
    };

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    box_t            req_box = '0;
    logic            cfg_valid = 1'b0;
    bcq_pkg::level_t cfg_data = '0;
    logic            busy;
    logic            done;
    bcq_pkg::value_t max_value;
    logic            is_safe;
    logic            cfg_ready;

    outcome_t        pending_outcomes [$];
    bcq_pkg::level_t active_level = LEVEL_ONE;
    int              mismatch_count = 0;
    int              quiet_cycles = 0;

    box_corner_quadratic_max_check dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .dim0_low  (req_box.d0_lo),
        .dim0_high (req_box.d0_hi),
        .dim1_low  (req_box.d1_lo),
        .dim1_high (req_box.d1_hi),
        .dim2_low  (req_box.d2_lo),
        .dim2_high (req_box.d2_hi),
        .dim3_low  (req_box.d3_lo),
        .dim3_high (req_box.d3_hi),
        .done      (done),
        .max_value (max_value),
        .is_safe   (is_safe),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Largest quadratic form over the 16 corners, exact, then floor and saturate
    function automatic outcome_t predict_box_max(input box_t b,
                                                 input bcq_pkg::level_t level);
        wide_t lo [4];
        wide_t hi [4];
        wide_t x [4];
        wide_t coef;
        wide_t acc;
        wide_t v;
        wide_t best;
        bcq_pkg::value_t top;
        outcome_t res;
        lo[0] = wide_t'(b.d0_lo); hi[0] = wide_t'(b.d0_hi);
        lo[1] = wide_t'(b.d1_lo); hi[1] = wide_t'(b.d1_hi);
        lo[2] = wide_t'(b.d2_lo); hi[2] = wide_t'(b.d2_hi);
        lo[3] = wide_t'(b.d3_lo); hi[3] = wide_t'(b.d3_hi);
        best = '0;
        for (int c = 0; c < 16; c++)
        begin
            x[0] = c[3] ? hi[0] : lo[0];
            x[1] = c[1] ? hi[2] : lo[2];
            x[2] = c[2] ? hi[1] : lo[1];
            x[3] = c[0] ? hi[3] : lo[3];
            acc = '0;
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    coef = wide_t'((MATRIX_E4[i][j] * 64'sd65536 + 64'sd5000)
                                   / 64'sd10000);
                    acc = acc + x[i] * x[j] * coef;
                end
            end
            v = acc >>> (3 * bcq_pkg::FRAC_BITS - bcq_pkg::OUT_FRAC);
            if (v > 96'sd140737488355327)
            begin
                v = 96'sd140737488355327;
            end
            else if (v < -96'sd140737488355328)
            begin
                v = -96'sd140737488355328;
            end
            if (c == 0 || v > best)
            begin
                best = v;
            end
        end
        top = bcq_pkg::value_t'(best);
        res.max_value = top;
        res.is_safe = (longint'(top) < longint'(level));
        return res;
    endfunction

    // Random box: mostly ordered bounds, plus full-range, reversed, tiny and extreme
    function automatic box_t random_box();
        bcq_pkg::data_t lo [4];
        bcq_pkg::data_t hi [4];
        bcq_pkg::data_t w;
        bcq_pkg::data_t t;
        int    kind;
        int    span;
        kind = $urandom_range(0, 99);
        span = (kind >= 75 && kind < 87) ? $urandom_range(0, 6) : $urandom_range(8, 21);
        for (int d = 0; d < 4; d++)
        begin
            lo[d] = bcq_pkg::data_t'($urandom) >>> (23 - span);
            w = bcq_pkg::data_t'($urandom) >>> (23 - span);
            if (w < 0)
            begin
                w = -w;
            end
            hi[d] = lo[d] + w;
            if (kind >= 40 && kind < 65)
            begin
                lo[d] = bcq_pkg::data_t'($urandom);
                hi[d] = bcq_pkg::data_t'($urandom);
            end
            else if (kind >= 65 && kind < 75)
            begin
                t = lo[d];
                lo[d] = hi[d];
                hi[d] = t;
            end
            else if (kind >= 87)
            begin
                for (int s = 0; s < 2; s++)
                begin
                    case ($urandom_range(0, 5))
                        0: t = D_MAX;
                        1: t = D_MIN;
                        2: t = 24'sd0;
                        3: t = D_NEG1;
                        4: t = D_LSB;
                        default: t = bcq_pkg::data_t'($urandom);
                    endcase
                    if (s == 0)
                    begin
                        lo[d] = t;
                    end
                    else
                    begin
                        hi[d] = t;
                    end
                end
            end
        end
        return '{lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], lo[3], hi[3]};
    endfunction

    // Idle cycles after a request: mostly none, some short, a few long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 15);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatch_count < 50)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Issue one request, wait for it to be taken, then idle for the gap
    task automatic send_box(input box_t b, input bit typed, input outcome_t typed_out,
                            input int gap);
        start <= 1'b1;
        req_box <= b;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (typed)
        begin
            pending_outcomes.push_back(typed_out);
        end
        else
        begin
            pending_outcomes.push_back(predict_box_max(b, active_level));
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write safe_level once every pending result is in
    task automatic write_safe_level(input bcq_pkg::level_t v);
        while (pending_outcomes.size() != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        active_level = v;
    endtask

    // Result check against the oldest pending outcome
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                note_mismatch($sformatf("result max_value=%0d with no request pending",
                                        max_value));
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (max_value !== want.max_value)
                begin
                    note_mismatch($sformatf("max_value got %0d expected %0d",
                                            max_value, want.max_value));
                end
                if (is_safe !== want.is_safe)
                begin
                    note_mismatch($sformatf("is_safe got %0b expected %0b (max_value %0d)",
                                            is_safe, want.is_safe, want.max_value));
                end
            end
        end
    end

    // Watchdog on cycles with no request, result or register write taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TIMEOUT @%0t: no progress for %0d cycles", $realtime, quiet_cycles);
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stimulus
    initial
    begin
        bcq_pkg::level_t lvl;
        bit              calm;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed boxes at the reset level
        for (int k = 0; k < NUM_DIRECTED; k++)
        begin
            send_box(DIRECTED_BOXES[k].box, DIRECTED_BOXES[k].typed,
                     DIRECTED_BOXES[k].outcome, pick_gap(1'b0));
        end
        start <= 1'b0;

        // random phases, each under its own level
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: lvl = '0;
                1: lvl = LEVEL_TOP;
                2: lvl = LEVEL_ONE;
                default: lvl = bcq_pkg::level_t'({$urandom, $urandom})
                               >> $urandom_range(3, 30);
            endcase
            write_safe_level(lvl);
            calm = (phase == 3 || phase == 7);
            for (int k = 0; k < BOXES_PER_PHASE; k++)
            begin
                send_box(random_box(), 1'b0, '0, pick_gap(calm));
            end
            start <= 1'b0;
        end

        while (pending_outcomes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/bcq_pkg.sv
hdl/bcq_corner_eval.sv
hdl/box_corner_quadratic_max_check.sv
hdl/bcq_checker.sv
tb/testbench.sv
